// ----- rtl/nwc_pkg.sv -----
package nwc_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_COEF_BITS = 16;

  localparam int DIM_W  = 14;
  localparam int AREA_W = 2 * DIM_W;
  localparam int PIX_W  = 24;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORM_MODE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHAN_EN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_LOW     = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_MID     = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_LAST    = 3'd6;

  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd2048;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd2048;
  localparam logic [63:0] RST_COEF_QUAD    = 64'h0100_0100_0100_0100;
  localparam logic [15:0] RST_COEF_ONE     = 16'h0100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DSET,
    ST_DGO,
    ST_DIV,
    ST_FIN
  } nwc_state_t;

endpackage

// ----- rtl/normalized_window_convolution.sv -----
// 3x3 convolution over an RGB raster stream with optional weight normalization.
// Input channel: in_valid/in_stall carry one item per handshake; in_command 0
// is a frame pixel, 1 a flush tick. After the last pixel send frame_width+1
// flush items. The result for pixel k leaves with item k + frame_width + 1.
// Output channel: out_valid/out_stall carry one filtered pixel per item, with
// out_frame_last on the final pixel and out_zero_weight on a zero weight sum in normalize mode.
// Config: cfg_we with cfg_index and cfg_data writes a register;
// a width or height write restarts the frame.
// Flow: one item in flight at a time. An item with no result goes back to idle
// after the load; an item with a result passes through nine tap steps of the
// MAC and a chain of COEF_BITS+12 divider cells.
// A finished item waits in the output register while the next item is taken;
// while out_stall holds, the block holds that item and the pipeline waits.
// Reset: registers return to defaults, window and counters clear; line store
// contents are not cleared and need no clearing pass.
module normalized_window_convolution
  import nwc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_last,
  output logic             out_zero_weight,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SUM_W = COEF_BITS + 12;
  localparam int TW    = COEF_BITS + 4;
  localparam int PW    = COEF_BITS + 9;

  nwc_state_t state_r, state_nxt;

  logic [11:0] fw_r, fh_r;
  logic        norm_r;
  logic [2:0]  chen_r;
  logic [63:0] cl_r, cm_r;
  logic [15:0] ct_r;

  logic [CW-1:0]     col_r;
  logic [DIM_W-1:0]  row_r;
  logic [AREA_W-1:0] emit_cnt_r;
  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  win_r [9];
  logic [8:0]        vmask_r;
  logic [3:0]        tap_r;
  logic              last_r;
  logic signed [SUM_W-1:0] acc_r [3];
  logic signed [TW-1:0]    wsum_r;
  logic [TW-1:0]           div_r;
  logic [2:0][SUM_W-1:0]   num0_r;
  logic [2:0]              neg_r;
  logic                    zw_r;
  logic [7:0]              res_r [3];

  logic       out_valid_r, out_last_r, out_zw_r;
  logic [7:0] out_px_r [3];

  logic [PIX_W-1:0] ram_a_q, ram_b_q;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [AREA_W-1:0] area;
  logic              emit, is_last;
  logic signed [DIM_W:0] cr, cc;
  logic [8:0]        vmask;
  logic [DIM_W-1:0]  col_inc, row_inc, col_nxt, row_nxt;

  logic signed [COEF_BITS-1:0] coef [9];
  logic signed [COEF_BITS-1:0] cur_coef;
  logic signed [PW-1:0]        prod [3];

  logic signed [TW-1:0] dsel;
  logic                 in_acc, out_take;

  logic                  dv_v   [SUM_W+1];
  logic [2:0][TW-1:0]    dv_rem [SUM_W+1];
  logic [2:0][SUM_W-1:0] dv_num [SUM_W+1];

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  assign w_eff = (fw_r == 12'd0) ? DIM_W'(1) :
                 ((DIM_W'(fw_r) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(fw_r));
  assign h_eff = (fh_r == 12'd0) ? DIM_W'(1) : DIM_W'(fh_r);
  assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);

  assign emit    = ((row_r >= DIM_W'(2)) || ((row_r == DIM_W'(1)) && (col_r != '0)))
                   && (emit_cnt_r < area);
  assign is_last = (emit_cnt_r + AREA_W'(1)) == area;

  always_comb begin
    logic signed [DIM_W:0] yy, xx;
    if (col_r != '0) begin
      cr = $signed({1'b0, row_r}) - (DIM_W+1)'(1);
      cc = $signed((DIM_W+1)'(col_r)) - (DIM_W+1)'(1);
    end else begin
      cr = $signed({1'b0, row_r}) - (DIM_W+1)'(2);
      cc = $signed({1'b0, w_eff}) - (DIM_W+1)'(1);
    end
    for (int t = 0; t < 9; t++) begin
      yy = cr + $signed((DIM_W+1)'(t / 3)) - (DIM_W+1)'(1);
      xx = cc + $signed((DIM_W+1)'(t % 3)) - (DIM_W+1)'(1);
      vmask[t] = (yy >= 0) && (yy < $signed({1'b0, h_eff})) &&
                 (xx >= 0) && (xx < $signed({1'b0, w_eff}));
    end
  end

  always_comb begin
    col_inc = DIM_W'(col_r) + DIM_W'(1);
    row_inc = row_r + DIM_W'(1);
    col_nxt = col_inc;
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_inc;
    end
    if (row_nxt > h_eff + DIM_W'(2)) begin
      row_nxt = h_eff + DIM_W'(2);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      coef[k]     = cl_r[16*k +: COEF_BITS];
      coef[k + 4] = cm_r[16*k +: COEF_BITS];
    end
    coef[8]  = ct_r[COEF_BITS-1:0];
    cur_coef = coef[tap_r];
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = cur_coef * $signed({1'b0, win_r[tap_r][8*ch +: 8]});
    end
  end

  assign dsel = norm_r ? wsum_r : TW'(256);

  nwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (state_r == ST_LOAD),
    .waddr (col_r),
    .wdata (pix_r),
    .raddr (col_r),
    .rdata (ram_a_q)
  );

  nwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (state_r == ST_LOAD),
    .waddr (col_r),
    .wdata (ram_a_q),
    .raddr (col_r),
    .rdata (ram_b_q)
  );

  assign dv_v[0]   = (state_r == ST_DGO);
  assign dv_rem[0] = '0;
  assign dv_num[0] = num0_r;

  for (genvar i = 0; i < SUM_W; i++) begin : g_div
    nwc_div_cell #(.NW(SUM_W), .DW(TW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[i]),
      .in_rem    (dv_rem[i]),
      .in_num    (dv_num[i]),
      .divisor   (div_r),
      .out_valid (dv_v[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_num   (dv_num[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = emit ? ST_MAC : ST_IDLE;
      ST_MAC:  if (tap_r == 4'd8) state_nxt = ST_DSET;
      ST_DSET: state_nxt = ST_DGO;
      ST_DGO:  state_nxt = ST_DIV;
      ST_DIV:  if (dv_v[SUM_W]) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= RST_FRAME_WIDTH;
      fh_r       <= RST_FRAME_HEIGHT;
      norm_r     <= 1'b1;
      chen_r     <= 3'b111;
      cl_r       <= RST_COEF_QUAD;
      cm_r       <= RST_COEF_QUAD;
      ct_r       <= RST_COEF_ONE;
      col_r      <= '0;
      row_r      <= '0;
      emit_cnt_r <= '0;
      for (int t = 0; t < 9; t++) begin
        win_r[t] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_LOAD) begin
        for (int t = 0; t < 3; t++) begin
          win_r[t*3]     <= win_r[t*3 + 1];
          win_r[t*3 + 1] <= win_r[t*3 + 2];
        end
        win_r[2] <= ram_b_q;
        win_r[5] <= ram_a_q;
        win_r[8] <= pix_r;
        if (emit && is_last) begin
          col_r      <= '0;
          row_r      <= '0;
          emit_cnt_r <= '0;
        end else begin
          col_r <= col_nxt[CW-1:0];
          row_r <= row_nxt;
          if (emit) begin
            emit_cnt_r <= emit_cnt_r + AREA_W'(1);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            fw_r <= cfg_data[11:0];
            col_r <= '0;
            row_r <= '0;
            emit_cnt_r <= '0;
          end
          REG_FRAME_HEIGHT: begin
            fh_r <= cfg_data[11:0];
            col_r <= '0;
            row_r <= '0;
            emit_cnt_r <= '0;
          end
          REG_NORM_MODE: norm_r <= cfg_data[0];
          REG_CHAN_EN:   chen_r <= cfg_data[2:0];
          REG_COEF_LOW:  cl_r   <= cfg_data;
          REG_COEF_MID:  cm_r   <= cfg_data;
          REG_COEF_LAST: ct_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_command ? '0 : {in_blue_in, in_green_in, in_red_in};
    end
    if (state_r == ST_LOAD) begin
      vmask_r <= vmask;
      last_r  <= is_last;
      tap_r   <= '0;
      wsum_r  <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= '0;
      end
    end
    if (state_r == ST_MAC) begin
      tap_r <= tap_r + 4'd1;
      if (vmask_r[tap_r]) begin
        wsum_r <= wsum_r + TW'(cur_coef);
        for (int ch = 0; ch < 3; ch++) begin
          acc_r[ch] <= acc_r[ch] + SUM_W'(prod[ch]);
        end
      end
    end
    if (state_r == ST_DSET) begin
      div_r <= dsel[TW-1] ? TW'(-dsel) : TW'(dsel);
      zw_r  <= norm_r && (wsum_r == '0) && (chen_r != 3'b000);
      for (int ch = 0; ch < 3; ch++) begin
        num0_r[ch] <= acc_r[ch][SUM_W-1] ? SUM_W'(-acc_r[ch]) : SUM_W'(acc_r[ch]);
        neg_r[ch]  <= acc_r[ch][SUM_W-1] ^ dsel[TW-1];
      end
    end
    if (state_r == ST_DIV && dv_v[SUM_W]) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (!chen_r[ch]) begin
          res_r[ch] <= win_r[4][8*ch +: 8];
        end else if (zw_r || (neg_r[ch] && dv_num[SUM_W][ch] != '0)) begin
          res_r[ch] <= 8'd0;
        end else if (dv_num[SUM_W][ch] > SUM_W'(255)) begin
          res_r[ch] <= 8'd255;
        end else begin
          res_r[ch] <= dv_num[SUM_W][ch][7:0];
        end
      end
    end
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_px_r[ch] <= res_r[ch];
      end
      out_last_r <= last_r;
      out_zw_r   <= zw_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = out_px_r[0];
  assign out_green_out   = out_px_r[1];
  assign out_blue_out    = out_px_r[2];
  assign out_frame_last  = out_last_r;
  assign out_zero_weight = out_zw_r;

`ifndef SYNTH
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v[SUM_W] |-> (state_r == ST_DIV))
    else $error("divider result outside divide wait");

  a_zw_needs_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_weight) |-> $past(norm_r))
    else $error("zero weight flag in raw mode");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("result dropped while output stalled");
`endif

endmodule

// ----- rtl/nwc_ram.sv -----
module nwc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/nwc_div_cell.sv -----
module nwc_div_cell #(
  parameter int NW = 28,
  parameter int DW = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [2:0][DW-1:0]     in_rem,
  input  logic [2:0][NW-1:0]     in_num,
  input  logic [DW-1:0]          divisor,
  output logic                   out_valid,
  output logic [2:0][DW-1:0]     out_rem,
  output logic [2:0][NW-1:0]     out_num
);

  logic              valid_r;
  logic [2:0][DW-1:0] rem_r, rem_nxt;
  logic [2:0][NW-1:0] num_r, num_nxt;

  always_comb begin
    logic [DW:0] sh;
    logic [DW:0] diff;
    for (int l = 0; l < 3; l++) begin
      sh   = {in_rem[l], in_num[l][NW-1]};
      diff = sh - {1'b0, divisor};
      if (sh >= {1'b0, divisor}) begin
        rem_nxt[l] = diff[DW-1:0];
        num_nxt[l] = {in_num[l][NW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = sh[DW-1:0];
        num_nxt[l] = {in_num[l][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;

endmodule
